@@ rtl/sirt_pkg.sv @@
`timescale 1ns / 1ps

package sirt_pkg;

  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 8;
  localparam int STEP_BITS = 4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] BASE_BIN    = 5'd2;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 5'd8;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_B     = 8'h62;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;

  // Control into the divider and status back from it.
  typedef struct packed {
    logic               start;
    logic [RADIX_W-1:0] base;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Bases below two act as two, bases above sixteen act as sixteen.
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    if (r < BASE_BIN) begin
      b = BASE_BIN;
    end else if (r > BASE_HEX) begin
      b = BASE_HEX;
    end else begin
      b = r;
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

@@ rtl/signed_integer_to_radix_text_core.sv @@
`timescale 1ns / 1ps

// Signed integer to text converter. Each input item is one signed
// two's complement value; the block returns its text in the base held in the
// radix register (two to sixteen, reset ten; smaller codes act as two and
// larger as sixteen), one ASCII character per output item, most significant
// first, with '-' for negative values, then "0b", "0" or "0x" for bases
// two, eight and sixteen, then the digits 0-9 and A-F. The last character
// of each number carries the last flag. The block takes one item at a time.
// The digits come out of one shared divider that retires four dividend bits
// per cycle. Digits are parked in a small RAM, least significant first, and
// read back in reverse. The radix register may be written only while no
// conversion is in flight.
module signed_integer_to_radix_text_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sirt_pkg::RADIX_W-1:0]  radix,
  // Input item channel.
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] value,
  // Output item channel.
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sirt_pkg::CHAR_W-1:0]   character,
  output logic                          last
);

  import sirt_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_SIGN  = 7'b0001000,
    S_PRE0  = 7'b0010000,
    S_PRE1  = 7'b0100000,
    S_DIGIT = 7'b1000000
  } state_t;

  state_t state;

  logic [RADIX_W-1:0] cfg_radix;
  logic [RADIX_W-1:0] base_r;
  logic               negative;
  logic [CNT_W-1:0]   dcount;
  logic [IDX_W-1:0]   ptr;
  logic [IDX_W-1:0]   ptr_next;

  logic                   accept;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] value_u;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic                   more;
  logic                   slot_free;
  logic                   emit;
  logic [CHAR_W-1:0]      ch;
  logic                   ch_last;
  logic                   has_prefix;

  div_ctrl_t              div_ctrl;
  div_stat_t              div_stat;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [VALUE_WIDTH-1:0] quotient;
  logic [DIGIT_W-1:0]     remainder;
  logic [DIGIT_W-1:0]     rdata;

  // The register is always ready; writes must arrive only between items, which the block does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_radix <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cfg_radix <= radix;
    end
  end

  // A new item is taken only while the sequencer is idle. The output register
  // may still hold the previous number's last character at that time.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // The magnitude of the most negative value still fits the unsigned width.
  assign value_u   = value;
  assign in_neg    = value_u[VALUE_WIDTH-1];
  assign magnitude = in_neg ? (~value_u + VALUE_WIDTH'(1)) : value_u;

  // Keep dividing while the quotient is nonzero and the digit store has room.
  assign more = (quotient != '0) && (dcount != CNT_W'(MAX_DIGITS - 1));

  assign dividend       = (state == S_IDLE) ? magnitude : quotient;
  assign div_ctrl.start = accept || (div_stat.done && more);
  assign div_ctrl.base  = (state == S_IDLE) ? eff_radix(cfg_radix) : base_r;

  sirt_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (dividend),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // The read address follows the next pointer, so the registered read data
  // always matches the current pointer, also while the output is stalled.
  sirt_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_store (
    .clk   (clk),
    .we    (div_stat.done),
    .waddr (dcount[IDX_W-1:0]),
    .wdata (remainder),
    .raddr (ptr_next),
    .rdata (rdata)
  );

  assign has_prefix = (base_r == BASE_BIN) || (base_r == BASE_OCT) || (base_r == BASE_HEX);

  // Character for the current state. Only a digit can close the text.
  always_comb begin
    ch      = '0;
    ch_last = 1'b0;
    case (state)
      S_SIGN:  ch = CHAR_MINUS;
      S_PRE0:  ch = CHAR_ZERO;
      S_PRE1:  ch = (base_r == BASE_BIN) ? CHAR_B : CHAR_X;
      S_DIGIT: begin
        ch      = digit_char(rdata);
        ch_last = (ptr == '0);
      end
      default: ch = '0;
    endcase
  end

  assign slot_free = !out_valid || !out_stall;
  assign emit = slot_free &&
                ((state == S_SIGN) || (state == S_PRE0) ||
                 (state == S_PRE1) || (state == S_DIGIT));

  always_comb begin
    ptr_next = ptr;
    if ((state == S_DIV) && div_stat.done && !more) begin
      ptr_next = dcount[IDX_W-1:0];
    end else if ((state == S_DIGIT) && emit && (ptr != '0)) begin
      ptr_next = ptr - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (accept) begin
      negative <= in_neg;
      base_r   <= eff_radix(cfg_radix);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      dcount <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            dcount <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            dcount <= dcount + 1'b1;
            if (!more) begin
              state <= S_LOAD;
            end
          end
        end
        // This state lets the last digit written settle in the read register.
        S_LOAD: begin
          if (negative) begin
            state <= S_SIGN;
          end else if (has_prefix) begin
            state <= S_PRE0;
          end else begin
            state <= S_DIGIT;
          end
        end
        S_SIGN: begin
          if (emit) begin
            state <= has_prefix ? S_PRE0 : S_DIGIT;
          end
        end
        S_PRE0: begin
          if (emit) begin
            state <= (base_r == BASE_OCT) ? S_DIGIT : S_PRE1;
          end
        end
        S_PRE1: begin
          if (emit) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (emit && (ptr == '0)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register: loads a character whenever the slot is free and a character state is active.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      character <= ch;
      last      <= ch_last;
    end
  end

  // The divider reports a digit only while the sequencer is dividing.
  assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  // An accepted item starts the divider with an empty digit count.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (div_stat.busy && (dcount == '0)))
    else $error("accepted item did not start a conversion");

  // Once characters are being sent, the divider is quiet.
  assert property (@(posedge clk) disable iff (rst)
    ((state != S_IDLE) && (state != S_DIV)) |-> !div_stat.busy)
    else $error("divider busy while characters are sent");

  // The digit count never passes the size of the digit store.
  assert property (@(posedge clk) disable iff (rst)
    (div_stat.done && (state == S_DIV)) |-> (dcount < CNT_W'(MAX_DIGITS)))
    else $error("digit store overflow");

endmodule

@@ rtl/sirt_ram.sv @@
`timescale 1ns / 1ps

module sirt_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sirt_divider.sv @@
`timescale 1ns / 1ps

module sirt_divider #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  sirt_pkg::div_ctrl_t    ctrl,
  input  logic [VALUE_WIDTH-1:0] dividend,
  output sirt_pkg::div_stat_t    stat,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [3:0]             remainder
);

  import sirt_pkg::*;

  localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W = STEPS * STEP_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0]     work;
  logic [DIGIT_W-1:0]   rem;
  logic [RADIX_W-1:0]   base_r;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;

  logic [DIGIT_W-1:0]   rem_next;
  logic [STEP_BITS-1:0] qbits;
  logic [RADIX_W-1:0]   trial;

  // Restoring division, a few dividend bits per cycle. The partial remainder
  // stays below the base, so every step works on five bits only.
  always_comb begin
    rem_next = rem;
    qbits    = '0;
    trial    = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {rem_next, work[PAD_W-1-i]};
      if (trial >= base_r) begin
        qbits[STEP_BITS-1-i] = 1'b1;
        trial = trial - base_r;
      end
      rem_next = trial[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(STEPS);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNT_W'(1));
      busy <= (cnt != CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      work   <= PAD_W'(dividend);
      rem    <= '0;
      base_r <= ctrl.base;
    end else if (busy) begin
      work <= {work[PAD_W-STEP_BITS-1:0], qbits};
      rem  <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = work[VALUE_WIDTH-1:0];
  assign remainder = rem;

endmodule
